FILE: design/spge_pkg.sv
// shared constants, codes and state type for the shortest path graph engine
// no dependencies
`default_nettype none

package spge_pkg;

  localparam int NumVerticesDef = 32;
  localparam int WeightBitsDef  = 16;

  localparam int CmdW      = 2;
  localparam int NodeW     = 5;
  localparam int WeightInW = 16;
  localparam int StatusW   = 3;
  localparam int DistW     = 21;
  localparam int MaxResults = 32;

  localparam logic [DistW-1:0] DistMax = '1;

  localparam logic [CmdW-1:0] CMD_ADD   = 2'd0;
  localparam logic [CmdW-1:0] CMD_ERASE = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_SRC_MISS  = 3'd1;
  localparam logic [StatusW-1:0] ST_DST_MISS  = 3'd2;
  localparam logic [StatusW-1:0] ST_BOTH_MISS = 3'd3;
  localparam logic [StatusW-1:0] ST_SAME      = 3'd4;
  localparam logic [StatusW-1:0] ST_UNREACH   = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADD_RD,
    S_ADD_WR1,
    S_ADD_WR2,
    S_ERASE,
    S_ERR,
    S_INIT,
    S_SCAN,
    S_DRAIN,
    S_NEXT,
    S_PATH_RD,
    S_PATH_WT
  } state_t;

endpackage

`default_nettype wire

FILE: design/shortest_path_graph_engine.sv
// top level of the shortest path graph engine: command decode, dijkstra sequencer
// depends on spge_pkg and spge_ram
`default_nettype none

// Keeps an undirected weighted graph of up to NUM_VERTICES stations in an
// adjacency memory of NUM_VERTICES^2 entries (valid bit plus weight) and
// answers shortest path queries with Dijkstra. After reset the adjacency
// memory is swept clear, one entry per cycle, while in_ready stays low. A
// query that runs settles one vertex per round; each round is one pass over
// all vertices through the adjacency and distance memories (one read each
// per cycle) that relaxes the neighbors and picks the next closest vertex
// in the same pass; afterwards the walk back reads the predecessor memory.
// One item is in work at a time. Results: one beat per path vertex from the
// destination back to the source, distance on the first beat only, saturated
// at the 21-bit limit; a failed query gives one beat with its status. Among
// equal distances the lowest numbered vertex is settled first.
module shortest_path_graph_engine #(
  parameter int NUM_VERTICES = spge_pkg::NumVerticesDef,
  parameter int WEIGHT_BITS  = spge_pkg::WeightBitsDef
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [spge_pkg::CmdW-1:0]      in_command,
  input  wire logic [spge_pkg::NodeW-1:0]     in_node_a,
  input  wire logic [spge_pkg::NodeW-1:0]     in_node_b,
  input  wire logic [spge_pkg::WeightInW-1:0] in_edge_weight,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [spge_pkg::StatusW-1:0]        out_status,
  output logic [spge_pkg::DistW-1:0]          out_distance,
  output logic [spge_pkg::NodeW-1:0]          out_path_node,
  output logic                                out_last
);

  import spge_pkg::*;

  localparam int NV = NUM_VERTICES;
  localparam int WB = WEIGHT_BITS;
  localparam int VB = $clog2(NV);
  localparam int EB = $clog2(NV * NV);
  localparam int DB = WB + VB;          // holds a sum of NV-1 weights
  localparam int CW = (DB > DistW) ? DB : DistW;
  localparam int RB = $clog2(MaxResults);

  // edge entry: {valid, weight}; distance entry: {distance, predecessor}
  localparam int EW = WB + 1;
  localparam int DEW = DB + VB;

  localparam logic [NV-1:0] OneHot0 = NV'(1);

  function automatic logic [EB-1:0] eidx(input logic [VB-1:0] row,
                                         input logic [VB-1:0] col);
    eidx = EB'(row) * EB'(NV) + EB'(col);
  endfunction

  function automatic logic [DistW-1:0] dsat(input logic [DB-1:0] d);
    if (CW'(d) > CW'(DistMax)) begin
      dsat = DistMax;
    end else begin
      dsat = DistW'(d);
    end
  endfunction

  // state and control
  state_t st_r, st_nxt;
  logic [NV-1:0] present_r, present_nxt;
  logic [NV-1:0] reached_r, reached_nxt;
  logic [NV-1:0] settled_r, settled_nxt;
  logic [EB-1:0] clr_r, clr_nxt;
  logic [VB-1:0] cnt_r, cnt_nxt;
  logic          ph_r, ph_nxt;
  logic          found_r, found_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s2_valid_r, s2_valid_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload
  logic [CmdW-1:0]    cmd_r;
  logic [VB-1:0]      a_r, b_r;
  logic               a_ok_r, b_ok_r;
  logic [WB-1:0]      w_r;
  logic [VB-1:0]      u_r, u_nxt;
  logic [DB-1:0]      du_r, du_nxt;
  logic [VB-1:0]      best_idx_r, best_idx_nxt;
  logic [DB-1:0]      best_d_r, best_d_nxt;
  logic [StatusW-1:0] err_r, err_nxt;
  logic [VB-1:0]      cur_r, cur_nxt;
  logic [RB-1:0]      n_r, n_nxt;
  logic [VB-1:0]      s1_idx_r, s1_idx_nxt;
  logic               s1_last_r, s1_last_nxt;
  logic               s2_cand_r, s2_cand_nxt;
  logic [DB-1:0]      s2_d_r, s2_d_nxt;
  logic [VB-1:0]      s2_idx_r, s2_idx_nxt;
  logic               s2_last_r, s2_last_nxt;
  logic [StatusW-1:0] out_status_r, out_status_nxt;
  logic [DistW-1:0]   out_distance_r, out_distance_nxt;
  logic [NodeW-1:0]   out_node_r, out_node_nxt;
  logic               out_last_r, out_last_nxt;

  // memory ports
  logic           e_we, e_re;
  logic [EB-1:0]  e_waddr, e_raddr;
  logic [EW-1:0]  e_wdata, e_rdata;
  logic           d_we, d_re;
  logic [VB-1:0]  d_waddr, d_raddr;
  logic [DEW-1:0] d_wdata, d_rdata;

  // relax stage
  logic [DB-1:0] rd_dist, nd, new_d;
  logic [VB-1:0] rd_pred;
  logic          e_ok, upd;

  logic in_acc, out_free;
  logic sp, dp;

  spge_ram #(.WIDTH(EW), .DEPTH(NV * NV)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  spge_ram #(.WIDTH(DEW), .DEPTH(NV)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  assign in_ready = (st_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_distance  = out_distance_r;
  assign out_path_node = out_node_r;
  assign out_last      = out_last_r;

  assign rd_dist = d_rdata[DEW-1:VB];
  assign rd_pred = d_rdata[VB-1:0];

  // relax the neighbor whose entries came back this cycle
  assign e_ok  = e_rdata[WB] && !settled_r[s1_idx_r];
  assign nd    = du_r + DB'(e_rdata[WB-1:0]);
  assign upd   = s1_valid_r && e_ok && (!reached_r[s1_idx_r] || nd < rd_dist);
  assign new_d = upd ? nd : rd_dist;

  assign sp = a_ok_r && present_r[a_r];
  assign dp = b_ok_r && present_r[b_r];

  always_comb begin
    st_nxt           = st_r;
    present_nxt      = present_r;
    reached_nxt      = reached_r;
    settled_nxt      = settled_r;
    clr_nxt          = clr_r;
    cnt_nxt          = cnt_r;
    ph_nxt           = ph_r;
    found_nxt        = found_r;
    u_nxt            = u_r;
    du_nxt           = du_r;
    best_idx_nxt     = best_idx_r;
    best_d_nxt       = best_d_r;
    err_nxt          = err_r;
    cur_nxt          = cur_r;
    n_nxt            = n_r;
    s1_valid_nxt     = 1'b0;
    s1_idx_nxt       = cnt_r;
    s1_last_nxt      = (cnt_r == VB'(NV - 1));
    s2_valid_nxt     = s1_valid_r;
    s2_cand_nxt      = (reached_r[s1_idx_r] || upd) && !settled_r[s1_idx_r];
    s2_d_nxt         = new_d;
    s2_idx_nxt       = s1_idx_r;
    s2_last_nxt      = s1_last_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_status_nxt   = out_status_r;
    out_distance_nxt = out_distance_r;
    out_node_nxt     = out_node_r;
    out_last_nxt     = out_last_r;

    e_we    = 1'b0;
    e_waddr = eidx(a_r, b_r);
    e_wdata = '0;
    e_re    = 1'b0;
    e_raddr = eidx(a_r, b_r);
    d_we    = 1'b0;
    d_waddr = s1_idx_r;
    d_wdata = {nd, u_r};
    d_re    = 1'b0;
    d_raddr = cnt_r;

    // relax write-back and reached mark
    if (upd) begin
      d_we = 1'b1;
      reached_nxt[s1_idx_r] = 1'b1;
    end

    // running minimum over the pass, strict compare keeps the lowest index
    if (s2_valid_r && s2_cand_r && (!found_r || s2_d_r < best_d_r)) begin
      found_nxt    = 1'b1;
      best_idx_nxt = s2_idx_r;
      best_d_nxt   = s2_d_r;
    end

    unique case (st_r)
      S_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_r;
        clr_nxt = clr_r + EB'(1);
        if (clr_r == EB'(NV * NV - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          st_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        st_nxt = S_IDLE;
        case (cmd_r)
          CMD_ADD: begin
            if (a_ok_r && b_ok_r) begin
              st_nxt = S_ADD_RD;
            end
          end
          CMD_ERASE: begin
            if (a_ok_r) begin
              present_nxt[a_r] = 1'b0;
              cnt_nxt = '0;
              ph_nxt  = 1'b0;
              st_nxt  = S_ERASE;
            end
          end
          CMD_QUERY: begin
            if (!sp && !dp) begin
              err_nxt = ST_BOTH_MISS;
              st_nxt  = S_ERR;
            end else if (!sp) begin
              err_nxt = ST_SRC_MISS;
              st_nxt  = S_ERR;
            end else if (!dp) begin
              err_nxt = ST_DST_MISS;
              st_nxt  = S_ERR;
            end else if (a_r == b_r) begin
              err_nxt = ST_SAME;
              st_nxt  = S_ERR;
            end else begin
              st_nxt = S_INIT;
            end
          end
          default: begin
            st_nxt = S_IDLE;
          end
        endcase
      end
      S_ADD_RD: begin
        e_re   = 1'b1;
        st_nxt = S_ADD_WR1;
      end
      S_ADD_WR1: begin
        present_nxt[a_r] = 1'b1;
        present_nxt[b_r] = 1'b1;
        // edges are stored symmetrically, so one lookup covers both ways
        if (!e_rdata[WB]) begin
          e_we    = 1'b1;
          e_wdata = {1'b1, w_r};
          st_nxt  = S_ADD_WR2;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_ADD_WR2: begin
        e_we    = 1'b1;
        e_waddr = eidx(b_r, a_r);
        e_wdata = {1'b1, w_r};
        st_nxt  = S_IDLE;
      end
      S_ERASE: begin
        e_we    = 1'b1;
        e_waddr = ph_r ? eidx(cnt_r, a_r) : eidx(a_r, cnt_r);
        ph_nxt  = !ph_r;
        if (ph_r) begin
          cnt_nxt = cnt_r + VB'(1);
          if (cnt_r == VB'(NV - 1)) begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = err_r;
          out_distance_nxt = '0;
          out_node_nxt     = '0;
          out_last_nxt     = 1'b1;
          st_nxt           = S_IDLE;
        end
      end
      S_INIT: begin
        settled_nxt = OneHot0 << a_r;
        reached_nxt = OneHot0 << a_r;
        u_nxt       = a_r;
        du_nxt      = '0;
        found_nxt   = 1'b0;
        cnt_nxt     = '0;
        d_we        = 1'b1;
        d_waddr     = a_r;
        d_wdata     = {{DB{1'b0}}, a_r};
        st_nxt      = S_SCAN;
      end
      S_SCAN: begin
        e_re         = 1'b1;
        e_raddr      = eidx(u_r, cnt_r);
        d_re         = 1'b1;
        s1_valid_nxt = 1'b1;
        cnt_nxt      = cnt_r + VB'(1);
        if (cnt_r == VB'(NV - 1)) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (s2_valid_r && s2_last_r) begin
          st_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (found_r) begin
          u_nxt                   = best_idx_r;
          du_nxt                  = best_d_r;
          settled_nxt[best_idx_r] = 1'b1;
          found_nxt               = 1'b0;
          cnt_nxt                 = '0;
          st_nxt                  = S_SCAN;
        end else if (reached_r[b_r]) begin
          cur_nxt = b_r;
          n_nxt   = '0;
          st_nxt  = S_PATH_RD;
        end else begin
          err_nxt = ST_UNREACH;
          st_nxt  = S_ERR;
        end
      end
      S_PATH_RD: begin
        d_re    = 1'b1;
        d_raddr = cur_r;
        st_nxt  = S_PATH_WT;
      end
      S_PATH_WT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = ST_OK;
          out_distance_nxt = (n_r == '0) ? dsat(rd_dist) : '0;
          out_node_nxt     = NodeW'(cur_r);
          out_last_nxt     = (cur_r == a_r) || (n_r == RB'(MaxResults - 1));
          if ((cur_r == a_r) || (n_r == RB'(MaxResults - 1))) begin
            st_nxt = S_IDLE;
          end else begin
            cur_nxt = rd_pred;
            n_nxt   = n_r + RB'(1);
            st_nxt  = S_PATH_RD;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      present_r   <= '0;
      reached_r   <= '0;
      settled_r   <= '0;
      clr_r       <= '0;
      cnt_r       <= '0;
      ph_r        <= 1'b0;
      found_r     <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      present_r   <= present_nxt;
      reached_r   <= reached_nxt;
      settled_r   <= settled_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      ph_r        <= ph_nxt;
      found_r     <= found_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_command;
      a_r    <= VB'(in_node_a);
      b_r    <= VB'(in_node_b);
      a_ok_r <= 32'(in_node_a) < 32'(NV);
      b_ok_r <= 32'(in_node_b) < 32'(NV);
      w_r    <= WB'(in_edge_weight);
    end
    u_r            <= u_nxt;
    du_r           <= du_nxt;
    best_idx_r     <= best_idx_nxt;
    best_d_r       <= best_d_nxt;
    err_r          <= err_nxt;
    cur_r          <= cur_nxt;
    n_r            <= n_nxt;
    s1_idx_r       <= s1_idx_nxt;
    s1_last_r      <= s1_last_nxt;
    s2_cand_r      <= s2_cand_nxt;
    s2_d_r         <= s2_d_nxt;
    s2_idx_r       <= s2_idx_nxt;
    s2_last_r      <= s2_last_nxt;
    out_status_r   <= out_status_nxt;
    out_distance_r <= out_distance_nxt;
    out_node_r     <= out_node_nxt;
    out_last_r     <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_settled_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (settled_r & ~reached_r) == '0)
    else $error("settled vertex not reached");

  a_relax_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (st_r == S_SCAN || st_r == S_DRAIN))
    else $error("relax beat outside of a scan pass");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second item taken while one is in work");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_last_r)
    else $error("error beat without last");
`endif

endmodule

`default_nettype wire

FILE: design/spge_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module spge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
